// File: rtl/packet_frame_encoder_crc32_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame encoder
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAME_ENCODER_CRC32_TOP_MACROS_SVH
`define PACKET_FRAME_ENCODER_CRC32_TOP_MACROS_SVH

// same-cycle implication
`define PFE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helper functions of the packet frame encoder.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam logic [15:0] MAX_PAYLOAD = 16'd255;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [7:0]  MAGIC_P     = 8'h50;
  localparam logic [7:0]  MAGIC_K     = 8'h4B;
  localparam logic [7:0]  MAGIC_T     = 8'h54;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam int          HDR_LEN     = 16;
  localparam logic [3:0]  HDR_LAST    = 4'(HDR_LEN - 1);
  localparam logic [3:0]  CRC_LAST    = 4'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // register index decoded from paddr[2]
  localparam logic REG_VERSION = 1'b0;

  typedef struct packed {
    logic               frame_start;
    logic [15:0]        pay_len;
    logic [31:0]        rx_stamp;
    logic signed [15:0] rssi_val;
    logic signed [15:0] snr_x10;
    logic [7:0]         payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       rejected;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_HEADER,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        has_byte;   // header item also carries the first payload byte
    logic        last;       // CRC follows this item's payload byte
    logic [15:0] pay_len;
    logic [31:0] rx_stamp;
    logic [15:0] rssi;
    logic [15:0] snr;
    logic [7:0]  payload_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_DATA,
    PH_CRC
  } phase_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input cmd_t cmd,
                                          input logic [7:0] version);
    logic [7:0] b;
    case (idx)
      4'd0:    b = MAGIC_P;
      4'd1:    b = MAGIC_K;
      4'd2:    b = MAGIC_T;
      4'd3:    b = MAGIC_P;
      4'd4:    b = version;
      4'd5:    b = 8'd0;
      4'd6:    b = cmd.pay_len[7:0];
      4'd7:    b = cmd.pay_len[15:8];
      4'd8:    b = cmd.rx_stamp[7:0];
      4'd9:    b = cmd.rx_stamp[15:8];
      4'd10:   b = cmd.rx_stamp[23:16];
      4'd11:   b = cmd.rx_stamp[31:24];
      4'd12:   b = cmd.rssi[7:0];
      4'd13:   b = cmd.rssi[15:8];
      4'd14:   b = cmd.snr[7:0];
      default: b = cmd.snr[15:8];
    endcase
    return b;
  endfunction

endpackage

// File: rtl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts input items, tracks frame state and turns items into commands.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pfe_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push,
  output pfe_pkg::cmd_t     push_cmd
);

  logic        in_frame_r, in_frame_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        accept;

  assign accept = in_valid && !q_full;

  always_comb begin
    in_frame_nxt            = in_frame_r;
    rem_nxt                 = rem_r;
    push                    = 1'b0;
    push_cmd.kind           = pfe_pkg::CMD_DATA;
    push_cmd.has_byte       = 1'b0;
    push_cmd.last           = 1'b0;
    push_cmd.pay_len        = in_item.pay_len;
    push_cmd.rx_stamp       = in_item.rx_stamp;
    push_cmd.rssi           = in_item.rssi_val;
    push_cmd.snr            = in_item.snr_x10;
    push_cmd.payload_byte   = in_item.payload_byte;
    if (accept) begin
      if (in_item.frame_start) begin
        push = 1'b1;
        if (in_item.pay_len > pfe_pkg::MAX_PAYLOAD) begin
          push_cmd.kind = pfe_pkg::CMD_REJECT;
          in_frame_nxt  = 1'b0;
          rem_nxt       = 16'd0;
        end else begin
          push_cmd.kind     = pfe_pkg::CMD_HEADER;
          push_cmd.has_byte = (in_item.pay_len != 16'd0);
          push_cmd.last     = (in_item.pay_len == 16'd1);
          in_frame_nxt      = (in_item.pay_len > 16'd1);
          rem_nxt           = (in_item.pay_len == 16'd0) ? 16'd0
                                                         : in_item.pay_len - 16'd1;
        end
      end else if (in_frame_r) begin
        // payload byte inside an open frame; stray bytes are dropped
        push          = 1'b1;
        push_cmd.kind = pfe_pkg::CMD_DATA;
        push_cmd.last = (rem_r == 16'd1);
        in_frame_nxt  = (rem_r != 16'd1);
        rem_nxt       = rem_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      rem_r      <= 16'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      rem_r      <= rem_nxt;
    end
  end

endmodule

// File: rtl/pfe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pfe_cmd_fifo
// Short command queue between front and back, flip-flop storage.
// ----------------------------------------------------------------------------
`include "packet_frame_encoder_crc32_top_macros.svh"

module pfe_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfe_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output pfe_pkg::cmd_t head
);

  localparam logic [pfe_pkg::FIFO_CW-1:0] DEPTH_CNT = pfe_pkg::FIFO_CW'(pfe_pkg::FIFO_DEPTH);

  pfe_pkg::cmd_t                 mem_r [pfe_pkg::FIFO_DEPTH];
  logic [pfe_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [pfe_pkg::FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [pfe_pkg::FIFO_CW-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full       = (count_r == DEPTH_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `PFE_ASSERT_NXT(a_fifo_count_up, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "fifo count did not grow on push")
  `PFE_ASSERT_IMP(a_fifo_ptr_gap, 1'b1, (pfe_pkg::FIFO_AW'(wr_ptr_r - rd_ptr_r) == count_r[pfe_pkg::FIFO_AW-1:0]), "fifo pointers disagree with count")

endmodule

// File: rtl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Serializes commands into frame bytes, one per cycle unless out_stall holds the output, and runs the CRC.
// ----------------------------------------------------------------------------
`include "packet_frame_encoder_crc32_top_macros.svh"

module pfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  pfe_pkg::cmd_t      head,
  input  logic [7:0]         version,
  input  logic               out_stall,
  output logic               pop,
  output logic               out_valid,
  output pfe_pkg::out_item_t out_item
);

  pfe_pkg::phase_t    phase_r, phase_nxt, eff;
  logic [3:0]         idx_r, idx_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic [31:0]        crc_inv;
  logic               out_valid_r, out_valid_nxt;
  pfe_pkg::out_item_t out_item_r;
  pfe_pkg::out_item_t item_d;
  logic               adv, emit;

  assign adv     = !out_valid_r || !out_stall;
  assign emit    = adv && head_valid;
  assign crc_inv = ~crc_r;

  always_comb begin
    // a data command has no header phase
    eff = phase_r;
    if (head.kind != pfe_pkg::CMD_HEADER && phase_r == pfe_pkg::PH_HDR) begin
      eff = pfe_pkg::PH_DATA;
    end
    phase_nxt       = phase_r;
    idx_nxt         = idx_r;
    crc_nxt         = crc_r;
    pop             = 1'b0;
    item_d.out_byte  = 8'd0;
    item_d.frame_end = 1'b0;
    item_d.rejected  = 1'b0;
    if (head.kind == pfe_pkg::CMD_REJECT) begin
      item_d.frame_end = 1'b1;
      item_d.rejected  = 1'b1;
      if (emit) begin
        pop       = 1'b1;
        crc_nxt   = pfe_pkg::CRC_INIT;
        phase_nxt = pfe_pkg::PH_HDR;
        idx_nxt   = 4'd0;
      end
    end else begin
      case (eff)
        pfe_pkg::PH_HDR: begin
          item_d.out_byte = pfe_pkg::hdr_byte(idx_r, head, version);
          if (emit) begin
            crc_nxt = pfe_pkg::crc32_byte((idx_r == 4'd0) ? pfe_pkg::CRC_INIT : crc_r,
                                          item_d.out_byte);
            if (idx_r == pfe_pkg::HDR_LAST) begin
              idx_nxt   = 4'd0;
              phase_nxt = head.has_byte ? pfe_pkg::PH_DATA : pfe_pkg::PH_CRC;
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end
        end
        pfe_pkg::PH_DATA: begin
          item_d.out_byte = head.payload_byte;
          if (emit) begin
            crc_nxt = pfe_pkg::crc32_byte(crc_r, head.payload_byte);
            idx_nxt = 4'd0;
            if (head.last) begin
              phase_nxt = pfe_pkg::PH_CRC;
            end else begin
              pop       = 1'b1;
              phase_nxt = pfe_pkg::PH_HDR;
            end
          end
        end
        pfe_pkg::PH_CRC: begin
          item_d.out_byte  = 8'(crc_inv >> {idx_r[1:0], 3'b000});
          item_d.frame_end = (idx_r == pfe_pkg::CRC_LAST);
          if (emit) begin
            if (idx_r == pfe_pkg::CRC_LAST) begin
              pop       = 1'b1;
              crc_nxt   = pfe_pkg::CRC_INIT;
              phase_nxt = pfe_pkg::PH_HDR;
              idx_nxt   = 4'd0;
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end
        end
        default: begin
          phase_nxt = pfe_pkg::PH_HDR;
          idx_nxt   = 4'd0;
        end
      endcase
    end
    out_valid_nxt = adv ? head_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pfe_pkg::PH_HDR;
      idx_r       <= 4'd0;
      crc_r       <= pfe_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= item_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PFE_ASSERT_IMP(a_reject_zero, out_valid_r && out_item_r.rejected, out_item_r.frame_end && (out_item_r.out_byte == 8'd0), "rejection item malformed")
  `PFE_ASSERT_NXT(a_crc_done, emit && head.kind != pfe_pkg::CMD_REJECT && eff == pfe_pkg::PH_CRC && idx_r == pfe_pkg::CRC_LAST, phase_r == pfe_pkg::PH_HDR && idx_r == 4'd0 && crc_r == pfe_pkg::CRC_INIT, "back not reset after CRC")

endmodule

// File: rtl/packet_frame_encoder_crc32_top.sv
// ----------------------------------------------------------------------------
// packet_frame_encoder_crc32_top
// Builds a header + payload + CRC-32 byte frame per received packet, or one rejection item if it is too long.
// ----------------------------------------------------------------------------
// The first frame byte of an item passes the command queue and the output register to out_valid.
// A start item yields 16 header bytes and its first payload byte (if any), a payload item one
// byte; 4 CRC bytes follow the last byte, and a rejection yields a single item. The back-end
// serializer emits one byte per cycle unless out_stall holds the output.
// A 4-entry command queue lets input items keep arriving while the header drains.
// Reset (synchronous, rst_n low) empties the queue, closes any frame, reloads the CRC, version=1.

module packet_frame_encoder_crc32_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          q_full, push, pop, head_valid;
  pfe_pkg::cmd_t push_cmd, head;
  logic [7:0]    version_r, version_nxt;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    version_nxt = version_r;
    if (cfg_wr && paddr[2] == pfe_pkg::REG_VERSION) begin
      version_nxt = pwdata[7:0];
    end
    prdata = (paddr[2] == pfe_pkg::REG_VERSION) ? {24'd0, version_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= pfe_pkg::VERSION_RST;
    end else begin
      version_r <= version_nxt;
    end
  end

  assign in_stall = q_full;

  pfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pfe_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  pfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .version    (version_r),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: frame encoder with CRC-32
// Sends radio packet items: well-formed frames, rejected lengths, stray
// payload and frames cut short. A shadow encoder predicts every output byte,
// and each output item is compared field by field against the oldest
// prediction. The run covers several version settings and idle/stall mixes,
// plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] VERSION_ADDR = {pfe_pkg::REG_VERSION, 2'b00};
  localparam int         SETTLE_CYCLES = 40;
  localparam int         DRAIN_LIMIT = 50000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pfe_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pfe_pkg::out_item_t out_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  packet_frame_encoder_crc32_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // shadow encoder state
  logic [7:0]         version_reg = pfe_pkg::VERSION_RST;
  logic [31:0]        crc_acc = pfe_pkg::CRC_INIT;
  logic [15:0]        bytes_left = '0;
  logic               frame_open = 1'b0;
  pfe_pkg::out_item_t frame_bytes_q[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  // ---------------- shadow encoder ----------------
  task automatic push_result(input logic [7:0] b, input logic fe, input logic rj);
    pfe_pkg::out_item_t o;
    o.out_byte  = b;
    o.frame_end = fe;
    o.rejected  = rj;
    frame_bytes_q.push_back(o);
  endtask

  task automatic push_frame_byte(input logic [7:0] b);
    logic [31:0] c;
    c = crc_acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ pfe_pkg::CRC_POLY) : (c >> 1);
    end
    crc_acc = c;
    push_result(b, 1'b0, 1'b0);
  endtask

  task automatic push_crc();
    logic [31:0] c;
    c = ~crc_acc;
    push_result(c[7:0], 1'b0, 1'b0);
    push_result(c[15:8], 1'b0, 1'b0);
    push_result(c[23:16], 1'b0, 1'b0);
    push_result(c[31:24], 1'b1, 1'b0);
    frame_open = 1'b0;
    bytes_left = '0;
    crc_acc    = pfe_pkg::CRC_INIT;
  endtask

  task automatic encode_item(input pfe_pkg::in_item_t it);
    if (it.frame_start) begin
      // a start always drops whatever frame was open
      frame_open = 1'b0;
      bytes_left = '0;
      crc_acc    = pfe_pkg::CRC_INIT;
      if (it.pay_len > pfe_pkg::MAX_PAYLOAD) begin
        push_result(8'h00, 1'b1, 1'b1);
        return;
      end
      push_frame_byte(pfe_pkg::MAGIC_P);
      push_frame_byte(pfe_pkg::MAGIC_K);
      push_frame_byte(pfe_pkg::MAGIC_T);
      push_frame_byte(pfe_pkg::MAGIC_P);
      push_frame_byte(version_reg);
      push_frame_byte(8'h00);
      push_frame_byte(it.pay_len[7:0]);
      push_frame_byte(it.pay_len[15:8]);
      push_frame_byte(it.rx_stamp[7:0]);
      push_frame_byte(it.rx_stamp[15:8]);
      push_frame_byte(it.rx_stamp[23:16]);
      push_frame_byte(it.rx_stamp[31:24]);
      push_frame_byte(it.rssi_val[7:0]);
      push_frame_byte(it.rssi_val[15:8]);
      push_frame_byte(it.snr_x10[7:0]);
      push_frame_byte(it.snr_x10[15:8]);
      if (it.pay_len == 16'd0) begin
        push_crc();
        return;
      end
      frame_open = 1'b1;
      bytes_left = it.pay_len;
    end else if (!frame_open) begin
      return;
    end
    push_frame_byte(it.payload_byte);
    bytes_left = bytes_left - 16'd1;
    if (bytes_left == 16'd0) push_crc();
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    pfe_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_q.size() == 0) begin
        $display("%0t: expected no item, actual byte=%02h end=%0b rej=%0b", $time,
                 out_item.out_byte, out_item.frame_end, out_item.rejected);
        mismatch_count++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want.out_byte, out_item.out_byte);
          mismatch_count++;
        end
        if (out_item.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b", $time,
                   want.frame_end, out_item.frame_end);
          mismatch_count++;
        end
        if (out_item.rejected !== want.rejected) begin
          $display("%0t: rejected expected %0b actual %0b", $time,
                   want.rejected, out_item.rejected);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------- input side ----------------
  task automatic send_item(input pfe_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    encode_item(it);
  endtask

  function automatic pfe_pkg::in_item_t start_item(input logic [15:0] len,
                                                   input logic [7:0] b);
    pfe_pkg::in_item_t it;
    it.frame_start  = 1'b1;
    it.pay_len      = len;
    it.rx_stamp     = $urandom;
    it.rssi_val     = 16'($urandom);
    it.snr_x10      = 16'($urandom);
    it.payload_byte = b;
    return it;
  endfunction

  // header fields are don't-care on payload items, so fill them with noise
  function automatic pfe_pkg::in_item_t payload_item(input logic [7:0] b);
    pfe_pkg::in_item_t it;
    it = start_item(16'($urandom), b);
    it.frame_start = 1'b0;
    return it;
  endfunction

  task automatic wait_drained();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (frame_bytes_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    // items that produce nothing may still be queued inside
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VERSION_ADDR;
    pwdata  <= {24'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    version_reg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) begin
      $display("%0t: version readback expected %02h actual %02h", $time, v, prdata[7:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_frames();
    pfe_pkg::in_item_t it;
    set_idling(30, 30);
    // empty payload, field extremes; payload byte must be ignored
    it = start_item(16'd0, 8'hA5);
    it.rx_stamp = 32'h0000_0000;
    it.rssi_val = 16'sh8000;
    it.snr_x10  = 16'sh7FFF;
    send_item(it);
    // one byte, opposite extremes
    it = start_item(16'd1, 8'h00);
    it.rx_stamp = 32'hFFFF_FFFF;
    it.rssi_val = 16'sh7FFF;
    it.snr_x10  = 16'sh8000;
    send_item(it);
    send_item(start_item(16'd2, 8'hFF));
    send_item(payload_item(8'h00));
    // stray payload while closed
    send_item(payload_item(8'h5A));
    // rejections, just over the limit and at the top
    send_item(start_item(pfe_pkg::MAX_PAYLOAD + 16'd1, 8'h11));
    send_item(payload_item(8'h22));
    send_item(start_item(16'hFFFF, 8'h33));
    // restart in the middle of a frame
    send_item(start_item(16'd5, 8'h01));
    send_item(payload_item(8'h02));
    send_item(start_item(16'd1, 8'h03));
    // rejection in the middle of a frame closes it
    send_item(start_item(16'd3, 8'h04));
    send_item(payload_item(8'h05));
    send_item(start_item(16'd300, 8'h06));
    send_item(payload_item(8'h07));
    send_item(start_item(16'd0, 8'h08));
    wait_drained();
  endtask

  task automatic test_version_extremes();
    set_idling(12, 12);
    write_version(8'h00);
    send_item(start_item(16'd0, 8'h00));
    send_item(start_item(16'd1, 8'hC3));
    wait_drained();
    write_version(8'hFF);
    send_item(start_item(16'd0, 8'h00));
    send_item(start_item(16'd1, 8'h3C));
    wait_drained();
  endtask

  // largest legal length in the header; a restart then cuts the frame short
  task automatic test_max_length();
    set_idling(5, 5);
    send_item(start_item(pfe_pkg::MAX_PAYLOAD, 8'($urandom)));
    for (int k = 0; k < 10; k++) send_item(payload_item(8'($urandom)));
    send_item(start_item(16'd0, 8'($urandom)));
    wait_drained();
  endtask

  task automatic test_output_hold();
    set_idling(0, 0);
    @(negedge clk);
    hold_left = 400;
    @(posedge clk);
    send_item(start_item(16'd16, 8'($urandom)));
    for (int k = 1; k < 16; k++) send_item(payload_item(8'($urandom)));
    send_item(start_item(16'd0, 8'($urandom)));
    wait_drained();
  endtask

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom_range(65535, 256));
    if (r < 72) return 16'($urandom_range(6));
    return 16'($urandom_range(40, 7));
  endfunction

  task automatic run_random_phase(input int target);
    int sent;
    int body;
    logic [15:0] len;
    sent = 0;
    while (sent < target) begin
      len = pick_length();
      send_item(start_item(len, 8'($urandom)));
      sent++;
      if (len != 16'd0 && len <= pfe_pkg::MAX_PAYLOAD) begin
        body = len - 1;
        // now and then cut the frame short so the next start lands mid-frame
        if ($urandom_range(99) < 10) body = $urandom_range(body);
        for (int k = 0; k < body; k++) begin
          send_item(payload_item(8'($urandom)));
          sent++;
        end
      end
      if (!frame_open && $urandom_range(99) < 10) send_item(payload_item(8'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    wait_drained();
    write_version(8'h00);
    set_idling(0, 0);
    run_random_phase(25);
    wait_drained();
    write_version(8'hFF);
    set_idling(81, 0);
    run_random_phase(25);
    wait_drained();
    write_version(8'($urandom));
    set_idling(0, 81);
    run_random_phase(25);
    wait_drained();
    write_version(pfe_pkg::VERSION_RST);
    set_idling(12, 12);
    run_random_phase(25);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_version_extremes();
    test_max_length();
    test_output_hold();
    test_random_traffic();
    if (frame_bytes_q.size() != 0) begin
      $display("%0t: expected %0d more items (next byte %02h), actual none", $time,
               frame_bytes_q.size(), frame_bytes_q[0].out_byte);
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[packet_frame_encoder_crc32_top] OK");
    end else begin
      $display("[packet_frame_encoder_crc32_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[packet_frame_encoder_crc32_top] ERROR");
    $finish;
  end

endmodule
